// ===== src/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// shared constants, types and helpers of the hamming triplet score core
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  localparam int MAX_CODES        = 1024;
  localparam int MAX_CODE_BYTES   = 16;
  localparam int BYTE_W           = 8;
  localparam int CODE_AW          = $clog2(MAX_CODES);
  localparam int BYTE_AW          = $clog2(MAX_CODE_BYTES);
  localparam int CSA_W            = CODE_AW + BYTE_AW;
  localparam int CODE_STORE_DEPTH = MAX_CODES * MAX_CODE_BYTES;
  localparam int BCNT_W           = $clog2(MAX_CODE_BYTES + 1);
  localparam int NCNT_W           = $clog2(MAX_CODES + 1);
  localparam int DIST_W           = $clog2(MAX_CODE_BYTES * BYTE_W + 1);
  localparam int POP_W            = $clog2(BYTE_W + 1);

  localparam int CB_W    = 5;
  localparam int NC_W    = 11;
  localparam int TPQ_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 2;
  localparam int OP_W    = 2;
  localparam int SCORE_W = 10;

  localparam logic [CFG_AW-1:0] REG_CODE_BYTES = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_CODES  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_TRIPLETS   = 2'd2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_SCORE = 2'd2;

  localparam logic [CB_W-1:0]  CODE_BYTES_RST = 5'd16;
  localparam logic [NC_W-1:0]  NUM_CODES_RST  = 11'd1024;
  localparam logic [TPQ_W-1:0] TRIPLETS_RST   = 16'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUERY,
    S_POS,
    S_NEG
  } state_t;

  typedef enum logic [1:0] {
    Q_IDLE,
    Q_LOAD,
    Q_CMP,
    Q_DRAIN
  } qstate_t;

  typedef struct packed {
    logic              we;
    logic [CSA_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } code_wr_t;

  typedef struct packed {
    logic               go;
    logic [CODE_AW-1:0] query;
    logic [BCNT_W-1:0]  kbytes;
    logic [NCNT_W-1:0]  ncodes;
  } qstart_t;

  typedef struct packed {
    logic               we;
    logic [CODE_AW-1:0] addr;
    logic [DIST_W-1:0]  data;
  } dist_wr_t;

  function automatic logic [POP_W-1:0] popcount8(input logic [BYTE_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      n = n + POP_W'(v[b]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/hts_ram.sv =====
// ----------------------------------------------------------------------------
// hts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module hts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/hts_query_unit.sv =====
// ----------------------------------------------------------------------------
// hts_query_unit
// code store and query sweep: xor popcount of the query against each in-use code
// ----------------------------------------------------------------------------
`default_nettype none

module hts_query_unit (
  input  wire               clk,
  input  wire               rst,
  input  hts_pkg::code_wr_t code_wr,
  input  hts_pkg::qstart_t  start,
  output hts_pkg::dist_wr_t dist_wr,
  output logic              busy
);
  import hts_pkg::*;

  qstate_t             state, state_next;
  logic [CODE_AW-1:0]  qsel;
  logic [BCNT_W-1:0]   kbytes;
  logic [NCNT_W-1:0]   ncodes;
  logic [BCNT_W-1:0]   j, j_next;
  logic [NCNT_W-1:0]   i, i_next;
  logic [BCNT_W-1:0]   kk;
  logic                kzero;
  logic                last_byte;
  logic                rd_en;
  logic [CSA_W-1:0]    rd_addr;
  logic [BYTE_W-1:0]   rd_data;

  logic                pv;
  logic                p_load;
  logic [BYTE_AW-1:0]  p_j;
  logic [CODE_AW-1:0]  p_i;
  logic                p_last;
  logic [DIST_W-1:0]   acc;
  logic [DIST_W-1:0]   sum;
  logic [BYTE_W-1:0]   qbytes [MAX_CODE_BYTES];

  hts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CODE_STORE_DEPTH)
  ) u_code_ram (
    .clk   (clk),
    .we    (code_wr.we),
    .waddr (code_wr.addr),
    .wdata (code_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign kzero     = (kbytes == '0);
  assign kk        = kzero ? BCNT_W'(1) : kbytes;
  assign last_byte = (j == kk - BCNT_W'(1));
  assign busy      = (state != Q_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= rd_en;
    end
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    i_next     = i;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state)
      Q_IDLE: begin
        if (start.go) begin
          j_next     = '0;
          i_next     = '0;
          state_next = (start.kbytes == '0) ? Q_CMP : Q_LOAD;
        end
      end
      Q_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = {qsel, j[BYTE_AW-1:0]};
        if (j == kbytes - BCNT_W'(1)) begin
          j_next     = '0;
          state_next = Q_CMP;
        end else begin
          j_next = j + BCNT_W'(1);
        end
      end
      Q_CMP: begin
        rd_en   = 1'b1;
        rd_addr = {i[CODE_AW-1:0], j[BYTE_AW-1:0]};
        if (last_byte) begin
          j_next = '0;
          i_next = i + NCNT_W'(1);
          if (i == ncodes - NCNT_W'(1)) begin
            state_next = Q_DRAIN;
          end
        end else begin
          j_next = j + BCNT_W'(1);
        end
      end
      Q_DRAIN: begin
        state_next = Q_IDLE;
      end
      default: begin
        state_next = Q_IDLE;
      end
    endcase
  end

  // data stage: one byte of the code compared per cycle
  always_comb begin
    sum = acc;
    if (!kzero) begin
      sum = acc + DIST_W'(popcount8(rd_data ^ qbytes[p_j]));
    end
    dist_wr.we   = pv && !p_load && p_last;
    dist_wr.addr = p_i;
    dist_wr.data = sum;
  end

  always_ff @(posedge clk) begin
    j      <= j_next;
    i      <= i_next;
    p_load <= (state == Q_LOAD);
    p_j    <= j[BYTE_AW-1:0];
    p_i    <= i[CODE_AW-1:0];
    p_last <= last_byte;
    if (state == Q_IDLE && start.go) begin
      qsel   <= start.query;
      kbytes <= start.kbytes;
      ncodes <= start.ncodes;
      acc    <= '0;
    end else if (pv && !p_load) begin
      acc <= p_last ? '0 : sum;
    end
    if (pv && p_load) begin
      qbytes[p_j] <= rd_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/hamming_triplet_score_core.sv =====
// ----------------------------------------------------------------------------
// hamming_triplet_score_core
// triplet margin scores over hamming distances of stored binary hash codes
// ----------------------------------------------------------------------------
// load byte: written to the code store in the cycle it is accepted
// query: query bytes loaded, then the codes in use compared, one code byte read per
//   cycle from the code store port; input stalls until the sweep ends (no sweep with num_codes 0)
// triplet: the pos distance is read on accept and the neg distance in S_POS, both on the single
//   distance store port, then the result is registered once the output is free; input stalls until then
// reset: registers return to 16 / 1024 / 1 and the triplet count clears;
//   code and distance stores are not cleared
`default_nettype none

module hamming_triplet_score_core (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [hts_pkg::CFG_AW-1:0]           cfg_index,
  input  wire  [hts_pkg::CFG_W-1:0]            cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [hts_pkg::OP_W-1:0]             op,
  input  wire  [hts_pkg::CODE_AW-1:0]          code_index,
  input  wire  [hts_pkg::BYTE_AW-1:0]          byte_index,
  input  wire  [hts_pkg::BYTE_W-1:0]           byte_value,
  input  wire  [hts_pkg::CODE_AW-1:0]          query_index,
  input  wire  [hts_pkg::CODE_AW-1:0]          pos_index,
  input  wire  [hts_pkg::CODE_AW-1:0]          neg_index,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [hts_pkg::SCORE_W-1:0]   score,
  output logic                                 last_triplet,
  output logic                                 index_error
);
  import hts_pkg::*;

  state_t              state, state_next;
  logic [CB_W-1:0]     code_bytes;
  logic [NC_W-1:0]     num_codes;
  logic [TPQ_W-1:0]    triplets_per_query;
  logic [TPQ_W-1:0]    triplet_count;
  logic [TPQ_W-1:0]    count_inc;
  logic                count_last;
  logic [BCNT_W-1:0]   kb_eff;
  logic [NCNT_W-1:0]   n_eff;
  logic                accept;
  logic                err_in;

  code_wr_t            code_wr;
  qstart_t             qstart;
  dist_wr_t            dist_wr;
  logic                qbusy;

  logic                dist_re;
  logic [CODE_AW-1:0]  dist_raddr;
  logic [DIST_W-1:0]   dist_rdata;
  logic [DIST_W-1:0]   pos_dist;
  logic [CODE_AW-1:0]  neg_q;
  logic                err_q;
  logic                last_q;
  logic                load_out;
  logic [SCORE_W-1:0]  diff;

  hts_query_unit u_query (
    .clk     (clk),
    .rst     (rst),
    .code_wr (code_wr),
    .start   (qstart),
    .dist_wr (dist_wr),
    .busy    (qbusy)
  );

  hts_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_CODES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_wr.we),
    .waddr (dist_wr.addr),
    .wdata (dist_wr.data),
    .re    (dist_re),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  assign kb_eff = (code_bytes > CB_W'(MAX_CODE_BYTES)) ? BCNT_W'(MAX_CODE_BYTES)
                                                       : BCNT_W'(code_bytes);
  assign n_eff  = (num_codes > NC_W'(MAX_CODES)) ? NCNT_W'(MAX_CODES)
                                                 : NCNT_W'(num_codes);

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign count_inc  = triplet_count + TPQ_W'(1);
  assign count_last = (count_inc == triplets_per_query);
  assign err_in     = (NCNT_W'(pos_index) >= n_eff) || (NCNT_W'(neg_index) >= n_eff);
  assign diff       = SCORE_W'(dist_rdata) - SCORE_W'(pos_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bytes         <= CODE_BYTES_RST;
      num_codes          <= NUM_CODES_RST;
      triplets_per_query <= TRIPLETS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CODE_BYTES: code_bytes         <= cfg_data[CB_W-1:0];
        REG_NUM_CODES:  num_codes          <= cfg_data[NC_W-1:0];
        REG_TRIPLETS:   triplets_per_query <= cfg_data[TPQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      triplet_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && op == OP_QUERY) begin
        triplet_count <= '0;
      end else if (accept && op == OP_SCORE) begin
        triplet_count <= count_last ? '0 : count_inc;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_SCORE) begin
      neg_q  <= neg_index;
      err_q  <= err_in;
      last_q <= count_last;
    end
    if (state == S_POS) begin
      pos_dist <= dist_rdata;
    end
    if (load_out) begin
      score        <= err_q ? '0 : {diff[SCORE_W-2:0], 1'b0};
      last_triplet <= last_q;
      index_error  <= err_q;
    end
  end

  always_comb begin
    state_next    = state;
    code_wr.we    = 1'b0;
    code_wr.addr  = {code_index, byte_index};
    code_wr.data  = byte_value;
    qstart.go     = 1'b0;
    qstart.query  = query_index;
    qstart.kbytes = kb_eff;
    qstart.ncodes = n_eff;
    dist_re       = 1'b0;
    dist_raddr    = pos_index;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD: begin
              code_wr.we = 1'b1;
            end
            OP_QUERY: begin
              if (n_eff != '0) begin
                qstart.go  = 1'b1;
                state_next = S_QUERY;
              end
            end
            OP_SCORE: begin
              dist_re    = 1'b1;
              state_next = S_POS;
            end
            default: ;
          endcase
        end
      end
      S_QUERY: begin
        if (!qbusy) begin
          state_next = S_IDLE;
        end
      end
      S_POS: begin
        dist_re    = 1'b1;
        dist_raddr = neg_q;
        state_next = S_NEG;
      end
      S_NEG: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_busy_not_idle: assert property (@(posedge clk) disable iff (rst)
    qbusy |-> state != S_IDLE)
    else $error("query sweep running while control is idle");

  a_dist_write_in_query: assert property (@(posedge clk) disable iff (rst)
    dist_wr.we |-> qbusy && state == S_QUERY)
    else $error("distance write outside a query sweep");

  a_score_sequence: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_SCORE) |=> state == S_POS ##1 state == S_NEG)
    else $error("triplet transaction did not read both distances");

  a_error_zero_score: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |-> score == '0)
    else $error("index error with nonzero score");

endmodule

`default_nettype wire

// ===== sim/hamming_triplet_score_core_tb.sv =====
// ----------------------------------------------------------------------------
// hamming_triplet_score_core_tb
// Self-checking bench for the hamming triplet score core. It loads hash codes
// byte by byte, selects query codes and scores triplets under several register
// settings, including the saturating and zero corners. A scoreboard class
// predicts every score transaction. Both channels get random gaps, and there
// is one long output hold-off so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hamming_triplet_score_core_tb;
  import hts_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0]  REG_SPARE = 2'd3;
  localparam logic [CODE_AW-1:0] FULL_CODE_TOP  = 10'd1023;
  localparam logic [CODE_AW-1:0] FULL_CODE_ODD  = 10'd682;
  localparam logic [CODE_AW-1:0] FULL_CODE_EVEN = 10'd341;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CODE_AW-1:0] code_index;
    logic [BYTE_AW-1:0] byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [CODE_AW-1:0] query_index;
    logic [CODE_AW-1:0] pos_index;
    logic [CODE_AW-1:0] neg_index;
  } txn_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last;
    logic                      err;
  } score_t;

  class margin_scoreboard;
    logic [BYTE_W-1:0] codes [MAX_CODES][MAX_CODE_BYTES];
    int                distances [MAX_CODES];
    logic [TPQ_W-1:0]  triplet_count;
    logic [CB_W-1:0]   cfg_code_bytes;
    logic [NC_W-1:0]   cfg_num_codes;
    logic [TPQ_W-1:0]  cfg_triplets;
    score_t            expected_scores [$];
    int                mismatches;

    function new();
      triplet_count  = '0;
      cfg_code_bytes = CODE_BYTES_RST;
      cfg_num_codes  = NUM_CODES_RST;
      cfg_triplets   = TRIPLETS_RST;
      mismatches     = 0;
    endfunction

    function int eff_codes();
      return (cfg_num_codes > MAX_CODES) ? MAX_CODES : int'(cfg_num_codes);
    endfunction

    function int eff_bytes();
      return (cfg_code_bytes > MAX_CODE_BYTES) ? MAX_CODE_BYTES : int'(cfg_code_bytes);
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CODE_BYTES: cfg_code_bytes = data[CB_W-1:0];
        REG_NUM_CODES:  cfg_num_codes  = data[NC_W-1:0];
        REG_TRIPLETS:   cfg_triplets   = data[TPQ_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_transaction(txn_t t);
      int n;
      int k;
      int d;
      int s;
      logic [TPQ_W-1:0] next_count;
      score_t e;
      n = eff_codes();
      k = eff_bytes();
      case (t.op)
        OP_LOAD: codes[t.code_index][t.byte_index] = t.byte_value;
        OP_QUERY: begin
          for (int i = 0; i < n; i++) begin
            d = 0;
            for (int j = 0; j < k; j++) begin
              d += $countones(codes[t.query_index][j] ^ codes[i][j]);
            end
            distances[i] = d;
          end
          triplet_count = '0;
        end
        OP_SCORE: begin
          next_count    = triplet_count + 1'b1;
          e.last        = (next_count == cfg_triplets);
          e.err         = (t.pos_index >= n) || (t.neg_index >= n);
          triplet_count = e.last ? '0 : next_count;
          s = 0;
          if (!e.err) begin
            s = 2 * (distances[t.neg_index] - distances[t.pos_index]);
            if (s > 511) s = 511;
            if (s < -512) s = -512;
          end
          e.score = s[SCORE_W-1:0];
          expected_scores.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_score(score_t got);
      score_t e;
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected score transaction: score %0d last %0b error %0b",
                   got.score, got.last, got.err);
      end else begin
        e = expected_scores.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("score mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     e.score, e.last, e.err, got.score, got.last, got.err);
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_AW-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           op = '0;
  logic [CODE_AW-1:0]        code_index = '0;
  logic [BYTE_AW-1:0]        byte_index = '0;
  logic [BYTE_W-1:0]         byte_value = '0;
  logic [CODE_AW-1:0]        query_index = '0;
  logic [CODE_AW-1:0]        pos_index = '0;
  logic [CODE_AW-1:0]        neg_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SCORE_W-1:0] score;
  logic                      last_triplet;
  logic                      index_error;

  margin_scoreboard sb = new();
  bit no_gaps = 1'b0;
  bit hold_request = 1'b0;

  hamming_triplet_score_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .code_index   (code_index),
    .byte_index   (byte_index),
    .byte_value   (byte_value),
    .query_index  (query_index),
    .pos_index    (pos_index),
    .neg_index    (neg_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .score        (score),
    .last_triplet (last_triplet),
    .index_error  (index_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic txn_t noise_txn(logic [OP_W-1:0] o);
    txn_t t;
    t.op          = o;
    t.code_index  = CODE_AW'($urandom_range(MAX_CODES - 1));
    t.byte_index  = BYTE_AW'($urandom_range(MAX_CODE_BYTES - 1));
    t.byte_value  = BYTE_W'($urandom_range(255));
    t.query_index = CODE_AW'($urandom_range(MAX_CODES - 1));
    t.pos_index   = CODE_AW'($urandom_range(MAX_CODES - 1));
    t.neg_index   = CODE_AW'($urandom_range(MAX_CODES - 1));
    return t;
  endfunction

  // only codes whose bytes in use are all loaded may take part in a query
  function automatic logic [CODE_AW-1:0] pick_query();
    int n;
    n = sb.eff_codes();
    if (sb.eff_bytes() == 0) return CODE_AW'($urandom_range(MAX_CODES - 1));
    if (n == 0 || $urandom_range(9) < 3) begin
      case ($urandom_range(2))
        0:       return FULL_CODE_TOP;
        1:       return FULL_CODE_ODD;
        default: return FULL_CODE_EVEN;
      endcase
    end
    return CODE_AW'($urandom_range(n - 1));
  endfunction

  task automatic send_item(input txn_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op          <= t.op;
    code_index  <= t.code_index;
    byte_index  <= t.byte_index;
    byte_value  <= t.byte_value;
    query_index <= t.query_index;
    pos_index   <= t.pos_index;
    neg_index   <= t.neg_index;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(t);
  endtask

  task automatic load_byte(input int ci, input int bi, input logic [BYTE_W-1:0] bv);
    txn_t t;
    t = noise_txn(OP_LOAD);
    t.code_index = CODE_AW'(ci);
    t.byte_index = BYTE_AW'(bi);
    t.byte_value = bv;
    send_item(t);
  endtask

  task automatic select_query(input logic [CODE_AW-1:0] qi);
    txn_t t;
    t = noise_txn(OP_QUERY);
    t.query_index = qi;
    send_item(t);
  endtask

  task automatic score_triplet(input int pi, input int ni);
    txn_t t;
    t = noise_txn(OP_SCORE);
    t.pos_index = CODE_AW'(pi);
    t.neg_index = CODE_AW'(ni);
    send_item(t);
  endtask

  task automatic write_config(input logic [CB_W-1:0] cb, input logic [NC_W-1:0] nc,
                              input logic [TPQ_W-1:0] tpq);
    logic [CFG_AW-1:0] idx;
    logic [CFG_W-1:0]  data;
    cfg_write <= 1'b1;
    for (int i = 0; i < (1 << CFG_AW); i++) begin
      idx = CFG_AW'(i);
      case (idx)
        REG_CODE_BYTES: data = CFG_W'(cb);
        REG_NUM_CODES:  data = CFG_W'(nc);
        REG_TRIPLETS:   data = CFG_W'(tpq);
        REG_SPARE:      data = CFG_W'($urandom);
        default:        data = '0;
      endcase
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      sb.write_reg(idx, data);
    end
    cfg_write <= 1'b0;
  endtask

  // a query gives no result, so wait out its longest walk as well
  task automatic drain_and_settle();
    int k;
    int n;
    in_valid <= 1'b0;
    k = sb.eff_bytes();
    n = sb.eff_codes();
    while (sb.expected_scores.size() != 0) @(posedge clk);
    repeat (k + n * ((k > 0) ? k : 1) + 20) @(posedge clk);
  endtask

  task automatic preload_codes();
    for (int i = 0; i < sb.eff_codes(); i++) begin
      for (int j = 0; j < sb.eff_bytes(); j++) begin
        load_byte(i, j, BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic random_item();
    int r;
    int n;
    txn_t t;
    r = $urandom_range(99);
    n = sb.eff_codes();
    if (r < 35) begin
      t = noise_txn(OP_LOAD);
      if (n > 0 && $urandom_range(1) == 1) t.code_index = CODE_AW'($urandom_range(n - 1));
    end else if (r < 42) begin
      t = noise_txn(OP_QUERY);
      t.query_index = pick_query();
    end else if (r < 94) begin
      t = noise_txn(OP_SCORE);
      if (n > 0 && $urandom_range(4) != 0) begin
        t.pos_index = CODE_AW'($urandom_range(n - 1));
        t.neg_index = CODE_AW'($urandom_range(n - 1));
      end
    end else begin
      t = noise_txn(OP_UNUSED);
    end
    send_item(t);
  endtask

  task automatic run_phase(input logic [CB_W-1:0] cb, input logic [NC_W-1:0] nc,
                           input logic [TPQ_W-1:0] tpq, input int count, input bit hold);
    drain_and_settle();
    write_config(cb, nc, tpq);
    preload_codes();
    select_query(pick_query());
    hold_request = hold;
    for (int k = 0; k < count; k++) begin
      no_gaps = (k >= count / 2) && (k < count / 2 + 30);
      random_item();
    end
    no_gaps = 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    int run_left;
    int g;
    logic next_stall;
    score_t got;
    hold_left = 0;
    run_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.score = score;
        got.last  = last_triplet;
        got.err   = index_error;
        sb.check_score(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (run_left > 0 || no_gaps) begin
        if (run_left > 0) run_left--;
        next_stall = 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          hold_left  = g - 1;
          next_stall = 1'b1;
        end else begin
          run_left   = $urandom_range(8);
          next_stall = 1'b0;
        end
      end
      out_stall <= next_stall;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_config(5'd16, 11'd8, 16'd3);
    preload_codes();
    for (int j = 0; j < MAX_CODE_BYTES; j++) begin
      load_byte(0, j, 8'h00);
      load_byte(1, j, 8'hFF);
      load_byte(FULL_CODE_TOP, j, BYTE_W'($urandom_range(255)));
      load_byte(FULL_CODE_ODD, j, BYTE_W'($urandom_range(255)));
      load_byte(FULL_CODE_EVEN, j, BYTE_W'($urandom_range(255)));
    end

    send_item(noise_txn(OP_UNUSED));
    select_query(0);
    score_triplet(0, 1);
    score_triplet(1, 0);
    score_triplet(7, 7);
    score_triplet(8, 0);
    score_triplet(0, FULL_CODE_TOP);
    score_triplet(FULL_CODE_TOP, FULL_CODE_TOP);
    select_query(FULL_CODE_TOP);
    score_triplet(3, 4);
    score_triplet(0, 1);
    select_query(FULL_CODE_ODD);
    score_triplet(1, 1);
    select_query(FULL_CODE_EVEN);
    score_triplet(6, 2);
    score_triplet(2, 6);
    select_query(1);
    score_triplet(0, 1);

    run_phase(5'd16, 11'd4, 16'd3, 60, 1'b1);
    run_phase(5'd1, 11'd1, 16'd1, 50, 1'b0);
    run_phase(5'd31, 11'd4, 16'd65535, 50, 1'b0);
    run_phase(5'd0, 11'd2047, 16'd0, 50, 1'b0);
    run_phase(5'd0, 11'd0, 16'd2, 40, 1'b0);
    run_phase(5'd4, 11'd16, 16'd7, 50, 1'b0);
    run_phase(5'd16, 11'd4, 16'd5, 50, 1'b0);
    drain_and_settle();

    if (sb.expected_scores.size() != 0) begin
      sb.mismatches++;
      $display("%0d expected score transactions never arrived", sb.expected_scores.size());
    end
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/hts_pkg.sv
src/hts_ram.sv
src/hts_query_unit.sv
src/hamming_triplet_score_core.sv
sim/hamming_triplet_score_core_tb.sv
